/* design/mahs_pkg.sv */
// Package: shared types, header field codes and lookup tables for the frame header scanner.
`timescale 1ns / 1ps

package mahs_pkg;

   // Header layout constants
   localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
   localparam logic [2:0]  SYNC_HIGH   = 3'b111;
   localparam logic [31:0] HDR_MASK    = 32'h001E0D03;

   // Raw version bits
   localparam logic [1:0]  VBITS_25    = 2'b00;
   localparam logic [1:0]  VBITS_RSVD  = 2'b01;
   localparam logic [1:0]  VBITS_2     = 2'b10;

   // Raw layer bits
   localparam logic [1:0]  LBITS_RSVD  = 2'b00;
   localparam logic [1:0]  LBITS_III   = 2'b01;
   localparam logic [1:0]  LBITS_II    = 2'b10;

   // Reported version codes
   localparam logic [1:0]  VER_25      = 2'd0;
   localparam logic [1:0]  VER_2       = 2'd1;
   localparam logic [1:0]  VER_1       = 2'd2;

   // Reported layer codes
   localparam logic [1:0]  LAYER_I     = 2'd1;
   localparam logic [1:0]  LAYER_II    = 2'd2;
   localparam logic [1:0]  LAYER_III   = 2'd3;

   // Bitrate index codes and reserved rate index
   localparam logic [3:0]  BRI_FREE    = 4'h0;
   localparam logic [3:0]  BRI_BAD     = 4'hF;
   localparam logic [1:0]  SRI_RSVD    = 2'b11;
   localparam logic [1:0]  MODE_MONO   = 2'b11;

   // Samples per frame
   localparam logic [10:0] SPF_L1      = 11'd384;
   localparam logic [10:0] SPF_HALF    = 11'd576;
   localparam logic [10:0] SPF_FULL    = 11'd1152;

   // Channel counts
   localparam logic [1:0]  CH_MONO     = 2'd1;
   localparam logic [1:0]  CH_STEREO   = 2'd2;

   // Result payload width on the stream (55 bits of fields padded to bytes)
   localparam int          RSP_WIDTH   = 56;

   // Sample rate in Hz, [version][rate index]
   localparam logic [15:0] RATE_TAB [0:2][0:2] = '{
      '{16'd11025, 16'd12000, 16'd8000},
      '{16'd22050, 16'd24000, 16'd16000},
      '{16'd44100, 16'd48000, 16'd32000}
   };

   // Bitrates in kbit/s, [bitrate index]
   localparam logic [8:0] BR_L1_V1 [0:15] = '{
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam logic [8:0] BR_L1_V2 [0:15] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam logic [8:0] BR_L2_V1 [0:15] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam logic [8:0] BR_L3_V1 [0:15] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam logic [8:0] BR_LOW_V2 [0:15] = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

   // Layer I frame length without padding: 4*floor(12000*br/rate),
   // [version][rate index][bitrate index]
   localparam logic [10:0] LEN_L1 [0:2][0:2][0:15] = '{
      '{ '{11'd0, 11'd136, 11'd208, 11'd240, 11'd276, 11'd348, 11'd416, 11'd484,
           11'd556, 11'd624, 11'd696, 11'd764, 11'd832, 11'd972, 11'd1112, 11'd0},
         '{11'd0, 11'd128, 11'd192, 11'd224, 11'd256, 11'd320, 11'd384, 11'd448,
           11'd512, 11'd576, 11'd640, 11'd704, 11'd768, 11'd896, 11'd1024, 11'd0},
         '{11'd0, 11'd192, 11'd288, 11'd336, 11'd384, 11'd480, 11'd576, 11'd672,
           11'd768, 11'd864, 11'd960, 11'd1056, 11'd1152, 11'd1344, 11'd1536, 11'd0} },
      '{ '{11'd0, 11'd68, 11'd104, 11'd120, 11'd136, 11'd172, 11'd208, 11'd240,
           11'd276, 11'd312, 11'd348, 11'd380, 11'd416, 11'd484, 11'd556, 11'd0},
         '{11'd0, 11'd64, 11'd96, 11'd112, 11'd128, 11'd160, 11'd192, 11'd224,
           11'd256, 11'd288, 11'd320, 11'd352, 11'd384, 11'd448, 11'd512, 11'd0},
         '{11'd0, 11'd96, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288, 11'd336,
           11'd384, 11'd432, 11'd480, 11'd528, 11'd576, 11'd672, 11'd768, 11'd0} },
      '{ '{11'd0, 11'd32, 11'd68, 11'd104, 11'd136, 11'd172, 11'd208, 11'd240,
           11'd276, 11'd312, 11'd348, 11'd380, 11'd416, 11'd452, 11'd484, 11'd0},
         '{11'd0, 11'd32, 11'd64, 11'd96, 11'd128, 11'd160, 11'd192, 11'd224,
           11'd256, 11'd288, 11'd320, 11'd352, 11'd384, 11'd416, 11'd448, 11'd0},
         '{11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
           11'd384, 11'd432, 11'd480, 11'd528, 11'd576, 11'd624, 11'd672, 11'd0} }
   };

   // Layer II frame length, [0 = MPEG-2/2.5, 1 = MPEG-1][rate index][bitrate index]
   localparam logic [10:0] LEN_L2 [0:1][0:2][0:15] = '{
      '{ '{11'd0, 11'd52, 11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
           11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0},
         '{11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
           11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960, 11'd0},
         '{11'd0, 11'd72, 11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
           11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440, 11'd0} },
      '{ '{11'd0, 11'd104, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313, 11'd365,
           11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd1253, 11'd0},
         '{11'd0, 11'd96, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288, 11'd336,
           11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd1152, 11'd0},
         '{11'd0, 11'd144, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432, 11'd504,
           11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd1728, 11'd0} }
   };

   // Layer III frame length, [version][rate index][bitrate index]
   localparam logic [10:0] LEN_L3 [0:2][0:2][0:15] = '{
      '{ '{11'd0, 11'd52, 11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
           11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0},
         '{11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
           11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960, 11'd0},
         '{11'd0, 11'd72, 11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
           11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440, 11'd0} },
      '{ '{11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
           11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0},
         '{11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
           11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0},
         '{11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
           11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0} },
      '{ '{11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
           11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0},
         '{11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
           11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0},
         '{11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
           11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0} }
   };

   // Decoded header fields
   typedef struct packed {
      logic        header_found;
      logic [1:0]  audio_version;
      logic [1:0]  layer_number;
      logic [10:0] frame_bytes;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [1:0]  channel_count;
      logic [10:0] samples_per_frame;
      logic        matches_reference;
   } result_type;

endpackage

/* design/mahs_window.sv */
// Byte history and the registered four-byte header window.
`timescale 1ns / 1ps

module mahs_window (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   input  logic        down_ready,
   output logic        in_ready,
   output logic        win_valid,
   output logic [31:0] win_word
);
   import mahs_pkg::*;

   logic [23:0] hist_ff, hist_in;
   logic        valid_ff, valid_in;
   logic [31:0] word_ff, word_in;
   logic        take;

   // Stage frees up when empty or when its word moves on
   assign in_ready = !valid_ff || down_ready;
   assign take     = in_valid && in_ready;

   // Oldest byte in the top, newest request byte in the bottom
   always_comb begin
      hist_in  = hist_ff;
      word_in  = word_ff;
      valid_in = valid_ff;
      if (take) begin
         hist_in = {hist_ff[15:0], in_byte};
         word_in = {hist_ff, in_byte};
      end
      if (take) begin
         valid_in = 1'b1;
      end else if (down_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         hist_ff  <= hist_in;
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign win_valid = valid_ff;
   assign win_word  = word_ff;

endmodule

/* design/mahs_decode.sv */
// Header check and field decode for one four-byte window.
`timescale 1ns / 1ps

module mahs_decode (
   input  logic [31:0]          word,
   input  logic [31:0]          ref_header,
   output mahs_pkg::result_type result
);
   import mahs_pkg::*;

   logic [1:0]  vbits, lbits, sri, mode, ver, layer;
   logic [3:0]  bri;
   logic        pad, ok;
   logic [15:0] rate;
   logic        l2_row;

   // Field split: byte 0 [31:24], byte 1 [23:16], byte 2 [15:8], byte 3 [7:0]
   assign vbits = word[20:19];
   assign lbits = word[18:17];
   assign bri   = word[15:12];
   assign sri   = word[11:10];
   assign pad   = word[9];
   assign mode  = word[7:6];

   assign ok = (word[31:24] == SYNC_BYTE) && (word[23:21] == SYNC_HIGH) &&
               (vbits != VBITS_RSVD) && (lbits != LBITS_RSVD) &&
               (bri != BRI_FREE) && (bri != BRI_BAD) && (sri != SRI_RSVD);

   // Version and layer codes
   always_comb begin
      case (vbits)
         VBITS_25: ver = VER_25;
         VBITS_2:  ver = VER_2;
         default:  ver = VER_1;
      endcase
      case (lbits)
         LBITS_III: layer = LAYER_III;
         LBITS_II:  layer = LAYER_II;
         default:   layer = LAYER_I;
      endcase
   end

   assign l2_row = (ver == VER_1);
   assign rate   = RATE_TAB[ver][sri];

   // Table lookups; everything stays zero without a valid header
   always_comb begin
      result = '0;
      if (ok) begin
         result.header_found   = 1'b1;
         result.audio_version  = ver;
         result.layer_number   = layer;
         result.sample_rate_hz = rate;
         result.channel_count  = (mode == MODE_MONO) ? CH_MONO : CH_STEREO;
         result.matches_reference = (((word ^ ref_header) & HDR_MASK) == '0);
         case (layer)
            LAYER_I: begin
               result.bitrate_kbps      = l2_row ? BR_L1_V1[bri] : BR_L1_V2[bri];
               result.frame_bytes       = LEN_L1[ver][sri][bri] + {8'd0, pad, 2'b00};
               result.samples_per_frame = SPF_L1;
            end
            LAYER_II: begin
               result.bitrate_kbps      = l2_row ? BR_L2_V1[bri] : BR_LOW_V2[bri];
               result.frame_bytes       = LEN_L2[l2_row][sri][bri] + {10'd0, pad};
               result.samples_per_frame = SPF_FULL;
            end
            default: begin
               result.bitrate_kbps      = l2_row ? BR_L3_V1[bri] : BR_LOW_V2[bri];
               result.frame_bytes       = LEN_L3[ver][sri][bri] + {10'd0, pad};
               result.samples_per_frame = l2_row ? SPF_FULL : SPF_HALF;
            end
         endcase
      end
   end

endmodule

/* design/mpeg_audio_header_sync_decoder_top.sv */
// Top level: stream ports, reference header register and the result register.
// A request's byte is registered in the window register when accepted, and its
// result is registered in the result register before it is offered.
// Throughput: one request per cycle unless rsp_tready stalls; the window and
// result registers each advance whenever the stage after them is free.
// Reset (synchronous, active high) clears the byte history, both valid flags
// and the reference header, so no header is seen before four new bytes.
`timescale 1ns / 1ps

module mpeg_audio_header_sync_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: data_byte [7:0]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   // rsp_tdata: header_found [0], audio_version [2:1], layer_number [4:3],
   // frame_bytes [15:5], bitrate_kbps [24:16], sample_rate_hz [40:25],
   // channel_count [42:41], samples_per_frame [53:43], matches_reference [54]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mahs_pkg::RSP_WIDTH-1:0] rsp_tdata,
   input  logic                          csr_wen,
   input  logic [31:0]                   csr_wdata
);
   import mahs_pkg::*;

   logic [31:0]      ref_hdr_ff, ref_hdr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic             out_ready;
   logic             win_valid;
   logic [31:0]      win_word;
   result_type       dec;

   // Reference header register
   assign ref_hdr_in = csr_wen ? csr_wdata : ref_hdr_ff;

   // Result register frees up when empty or taken
   assign out_ready = !rsp_valid_ff || rsp_tready;

   mahs_window u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .down_ready (out_ready),
      .in_ready   (req_tready),
      .win_valid  (win_valid),
      .win_word   (win_word)
   );

   mahs_decode u_decode (
      .word       (win_word),
      .ref_header (ref_hdr_ff),
      .result     (dec)
   );

   // Load the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in = win_valid;
         rsp_data_in  = {1'b0, dec.matches_reference, dec.samples_per_frame,
                         dec.channel_count, dec.sample_rate_hz, dec.bitrate_kbps,
                         dec.frame_bytes, dec.layer_number, dec.audio_version,
                         dec.header_found};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ref_hdr_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ref_hdr_ff   <= ref_hdr_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (win_valid && rsp_valid_ff && !rsp_tready))
      else $error("request side stalled with room in the pipeline");

   a_no_header_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[RSP_WIDTH-1:1] == '0))
      else $error("fields set without a header");

   a_header_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |->
         ((rsp_tdata[4:3] != 2'd0) && (rsp_tdata[15:5] != 11'd0) &&
          (rsp_tdata[42:41] != 2'd0) && (rsp_tdata[25 +: 16] != 16'd0)))
      else $error("header reported with empty fields");

   a_window_to_result: assert property (@(posedge clock) disable iff (reset)
      (win_valid && out_ready) |=> rsp_tvalid)
      else $error("window word lost on its way to the result register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !win_valid && (ref_hdr_ff == '0)))
      else $error("valid flags not cleared by reset");

endmodule
